/* rtl/core/rcfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the remote-control frame receiver/decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

	// Frame geometry
	localparam int FRAME_BYTES = 18;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(FRAME_BYTES);

	// Tick counter saturates at its full width
	localparam int                TICK_W   = 17;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// Configuration port
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int TMO_W    = 16;
	localparam int CENTER_W = 11;

	localparam logic [TMO_W-1:0]    TIMEOUT_RESET = 16'd100;
	localparam logic [CENTER_W-1:0] CENTER_RESET  = 11'd1024;

	// Register index (paddr[2])
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_CENTER  = 1'b1;

	// Input action codes
	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_IDLE = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// Link status codes
	localparam logic [1:0] LINK_FRESH = 2'd0;
	localparam logic [1:0] LINK_HELD  = 2'd1;
	localparam logic [1:0] LINK_LOST  = 2'd2;

	// Raw field masks
	localparam logic [7:0] MASK_LO3 = 8'h07;
	localparam logic [7:0] MASK_HI5 = 8'hF8;
	localparam logic [7:0] MASK_LO6 = 8'h3F;
	localparam logic [7:0] MASK_HI2 = 8'hC0;
	localparam logic [7:0] MASK_LO1 = 8'h01;
	localparam logic [7:0] MASK_HI7 = 8'hFE;
	localparam logic [7:0] MASK_LO4 = 8'h0F;
	localparam logic [7:0] MASK_SW  = 8'h03;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} rcfd_in_t;

	typedef struct packed {
		logic signed [11:0] channel_0;
		logic signed [11:0] channel_1;
		logic signed [11:0] channel_2;
		logic signed [11:0] channel_3;
		logic signed [15:0] wheel;
		logic        [3:0]  switches;
		logic signed [15:0] mouse_x;
		logic signed [15:0] mouse_y;
		logic signed [15:0] mouse_z;
		logic        [15:0] mouse_buttons;
		logic        [15:0] keys;
		logic        [1:0]  link_status;
	} rcfd_out_t;

	typedef struct packed {
		logic [TMO_W-1:0]    timeout_ticks;
		logic [CENTER_W-1:0] channel_center;
	} rcfd_cfg_t;

	typedef struct packed {
		logic wr_byte;
		logic idle;
	} rcfd_frame_ctl_t;

endpackage

/* rtl/core/rcfd_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_cfg
// APB register bank: timeout in ticks and channel center value.
// ----------------------------------------------------------------------------
module rcfd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rcfd_pkg::APB_AW-1:0]   paddr,
	input  logic [rcfd_pkg::APB_DW-1:0]   pwdata,
	output logic [rcfd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output rcfd_pkg::rcfd_cfg_t           cfg
);

	logic [rcfd_pkg::TMO_W-1:0]    timeout_q;
	logic [rcfd_pkg::CENTER_W-1:0] center_q;
	logic                          wr_en;
	logic                          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rcfd_pkg::TIMEOUT_RESET;
			center_q  <= rcfd_pkg::CENTER_RESET;
		end else if (wr_en) begin
			if (reg_sel == rcfd_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[rcfd_pkg::TMO_W-1:0];
			end else begin
				center_q <= pwdata[rcfd_pkg::CENTER_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == rcfd_pkg::REG_TIMEOUT) begin
			prdata = {{(rcfd_pkg::APB_DW - rcfd_pkg::TMO_W){1'b0}}, timeout_q};
		end else begin
			prdata = {{(rcfd_pkg::APB_DW - rcfd_pkg::CENTER_W){1'b0}}, center_q};
		end
	end

	assign cfg.timeout_ticks  = timeout_q;
	assign cfg.channel_center = center_q;

endmodule

/* rtl/core/rcfd_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_frame
// Frame byte store, byte count and field unpacking of a complete frame.
// ----------------------------------------------------------------------------
module rcfd_frame (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rcfd_pkg::rcfd_frame_ctl_t       ctl,
	input  logic [7:0]                      byte_in,
	input  logic [rcfd_pkg::CENTER_W-1:0]   center,
	output logic                            complete,
	output rcfd_pkg::rcfd_out_t             decoded
);

	logic [7:0]                 store_q [rcfd_pkg::FRAME_BYTES];
	logic [rcfd_pkg::CNT_W-1:0] count_q;
	logic                       full;
	logic [10:0]                raw_c0, raw_c1, raw_c2, raw_c3;
	logic [15:0]                raw_wheel;

	assign full     = (count_q == rcfd_pkg::CNT_W'(rcfd_pkg::FRAME_BYTES));
	assign complete = full;

	// Store bytes in arrival order; drop anything past the frame length
	always_ff @(posedge clk) begin
		if (ctl.wr_byte && !full) begin
			store_q[count_q[rcfd_pkg::IDX_W-1:0]] <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.idle) begin
			count_q <= '0;
		end else if (ctl.wr_byte && !full) begin
			count_q <= count_q + rcfd_pkg::CNT_W'(1);
		end
	end

	// Unpack 11-bit sticks packed little-endian across bytes 0..5
	always_comb begin
		raw_c0 = {3'((store_q[1] & rcfd_pkg::MASK_LO3)), store_q[0]};
		raw_c1 = {6'((store_q[2] & rcfd_pkg::MASK_LO6)),
			5'((store_q[1] & rcfd_pkg::MASK_HI5) >> 3)};
		raw_c2 = {1'((store_q[4] & rcfd_pkg::MASK_LO1)), store_q[3],
			2'((store_q[2] & rcfd_pkg::MASK_HI2) >> 6)};
		raw_c3 = {4'((store_q[5] & rcfd_pkg::MASK_LO4)),
			7'((store_q[4] & rcfd_pkg::MASK_HI7) >> 1)};
		raw_wheel = {store_q[17], store_q[16]};

		decoded.channel_0 = {1'b0, raw_c0} - {1'b0, center};
		decoded.channel_1 = {1'b0, raw_c1} - {1'b0, center};
		decoded.channel_2 = {1'b0, raw_c2} - {1'b0, center};
		decoded.channel_3 = {1'b0, raw_c3} - {1'b0, center};
		decoded.wheel     = raw_wheel - {5'b0, center};
		decoded.switches  = {2'((store_q[5] >> 6) & rcfd_pkg::MASK_SW),
			2'((store_q[5] >> 4) & rcfd_pkg::MASK_SW)};
		decoded.mouse_x       = {store_q[7], store_q[6]};
		decoded.mouse_y       = {store_q[9], store_q[8]};
		decoded.mouse_z       = {store_q[11], store_q[10]};
		decoded.mouse_buttons = {store_q[13], store_q[12]};
		decoded.keys          = {store_q[15], store_q[14]};
		decoded.link_status   = rcfd_pkg::LINK_FRESH;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rcfd_pkg::CNT_W'(rcfd_pkg::FRAME_BYTES))
		else $error("byte count ran past frame length");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.idle |=> (count_q == '0))
		else $error("byte count not cleared on line idle");
`endif

endmodule

/* rtl/core/rc_frame_receiver_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_frame_receiver_decoder
// Remote-control frame receiver: collects 18-byte frames, unpacks them on
// line idle and reports the latched snapshot with a link status.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------
//  in      | in_valid / in_stall         | in_data  (action, rx_byte)
//  out     | out_valid / out_stall       | out_data (snapshot, link_status)
//  cfg     | psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
//  One input transaction per cycle while in_stall is low; its result is
//  registered by the single decode stage, in the skid if the output stalls.
//  Byte transactions and action code 3 produce no result.
//  A two-entry output (result register plus skid) lets the input keep
//  flowing while a result waits; in_stall rises only when both are full.
//  Reset clears the byte count, snapshot, link state and tick counter;
//  the frame store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module rc_frame_receiver_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rcfd_pkg::rcfd_in_t              in_data,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output rcfd_pkg::rcfd_out_t             out_data,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rcfd_pkg::APB_AW-1:0]     paddr,
	input  logic [rcfd_pkg::APB_DW-1:0]     pwdata,
	output logic [rcfd_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	rcfd_pkg::rcfd_cfg_t        cfg;
	rcfd_pkg::rcfd_frame_ctl_t  frame_ctl;
	rcfd_pkg::rcfd_out_t        decoded;
	rcfd_pkg::rcfd_out_t        snap_q;
	rcfd_pkg::rcfd_out_t        res;
	rcfd_pkg::rcfd_out_t        out_q;
	rcfd_pkg::rcfd_out_t        skid_q;
	logic                       out_valid_q;
	logic                       skid_valid_q;
	logic                       online_q;
	logic [rcfd_pkg::TICK_W-1:0] ticks_q;
	logic [rcfd_pkg::TICK_W-1:0] ticks_inc;
	logic [rcfd_pkg::TICK_W-1:0] ticks_eval;
	logic                       frame_done;
	logic                       accept;
	logic                       is_byte;
	logic                       is_idle;
	logic                       is_tick;
	logic                       decode_now;
	logic                       res_valid;
	logic                       out_take;
	logic [1:0]                 held_status;

	// Register bank
	rcfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input handshake and action decode
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign is_byte  = (in_data.action == rcfd_pkg::ACT_BYTE);
	assign is_idle  = (in_data.action == rcfd_pkg::ACT_IDLE);
	assign is_tick  = (in_data.action == rcfd_pkg::ACT_TICK);

	assign frame_ctl.wr_byte = accept && is_byte;
	assign frame_ctl.idle    = accept && is_idle;

	// Frame store and unpacking
	rcfd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (frame_ctl),
		.byte_in  (in_data.rx_byte),
		.center   (cfg.channel_center),
		.complete (frame_done),
		.decoded  (decoded)
	);

	// Tick counter: saturate, and judge the timeout on the incremented value on a tick
	assign ticks_inc  = (ticks_q == rcfd_pkg::TICK_MAX) ? ticks_q
		: ticks_q + rcfd_pkg::TICK_W'(1);
	assign ticks_eval = is_tick ? ticks_inc : ticks_q;
	assign held_status = (!online_q
		|| ticks_eval > {{(rcfd_pkg::TICK_W - rcfd_pkg::TMO_W){1'b0}}, cfg.timeout_ticks})
		? rcfd_pkg::LINK_LOST : rcfd_pkg::LINK_HELD;

	// A complete frame on idle is decoded and reported fresh in the same pass
	assign decode_now = is_idle && frame_done;
	assign res_valid  = accept && (is_idle || is_tick);

	always_comb begin
		res = decode_now ? decoded : snap_q;
		res.link_status = decode_now ? rcfd_pkg::LINK_FRESH : held_status;
	end

	// Link state and snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q   <= '0;
			online_q <= 1'b0;
			ticks_q  <= '0;
		end else if (accept) begin
			if (decode_now) begin
				snap_q   <= decoded;
				online_q <= 1'b1;
				ticks_q  <= '0;
			end else if (is_tick) begin
				ticks_q <= ticks_inc;
			end
		end
	end

	// Result register plus skid: drain skid first to keep order
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_fresh_goes_online: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && decode_now) |=> (online_q && ticks_q == '0))
		else $error("decoded frame did not set the link online");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_tick) |=> (ticks_q != '0))
		else $error("tick counter did not advance");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid_q) |=> out_valid_q)
		else $error("result lost between decode and output register");
`endif

endmodule
